// ===== design/signed_int_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii assertion macros
// Property wrappers for the decimal text converter; compiled out by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef ASSERT_OFF
`define SIDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SIDA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg
// Widths, character codes and state encoding for the decimal text converter.
// ----------------------------------------------------------------------------
package sida_pkg;

	localparam int VALUE_W  = 32;
	localparam int CHAR_W   = 6;
	localparam int DIGITS   = 10;
	localparam int BCD_W    = 4 * DIGITS;
	localparam int BITCNT_W = $clog2(VALUE_W);
	localparam int DIGCNT_W = $clog2(DIGITS + 1);

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [1:0]        CHAR_DIGIT_HI = 2'b11;  // '0'..'9' = 6'b11_dddd

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

// ===== design/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// A request is taken when start is high and busy is low. The block then stays
// busy for binary-to-BCD conversion, one input bit per cycle through a
// shift-and-add-3 register, then for a scan of the BCD digit positions from
// the top, one per cycle. Characters appear on character and last for one
// cycle each, marked by strobe; the receiver cannot stall them. A minus sign
// comes out in the first cycle after the request, the leading zero positions
// pass without a strobe, and the remaining digits then follow in consecutive
// cycles, last high on the final one. Busy is already low while the final
// character is shown, so a new request can be taken at the edge that ends
// that cycle.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [sida_pkg::VALUE_W-1:0] value,
	output logic                                busy,
	output logic                                strobe,
	output logic        [sida_pkg::CHAR_W-1:0]  character,
	output logic                                last
);
	import sida_pkg::*;

	state_t                state_q;
	logic [VALUE_W-1:0]    mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BITCNT_W-1:0]   bitcnt_q;
	logic [DIGCNT_W-1:0]   digcnt_q;
	logic                  started_q;
	logic                  strobe_q;
	logic [CHAR_W-1:0]     character_q;
	logic                  last_q;

	logic [BCD_W-1:0]      bcd_adj;
	logic [3:0]            top_digit;
	logic                  emit_now;
	logic                  accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign emit_now  = started_q || (top_digit != 4'd0) || (digcnt_q == DIGCNT_W'(1));

	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ?
				bcd_q[4*d +: 4] + 4'd3 : bcd_q[4*d +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			strobe_q  <= 1'b0;
			started_q <= 1'b0;
			bitcnt_q  <= '0;
			digcnt_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						strobe_q  <= value[VALUE_W-1];
						bitcnt_q  <= BITCNT_W'(VALUE_W - 1);
						started_q <= 1'b0;
					end
				end
				ST_CONV: begin
					bitcnt_q <= bitcnt_q - BITCNT_W'(1);
					if (bitcnt_q == '0) begin
						state_q  <= ST_EMIT;
						digcnt_q <= DIGCNT_W'(DIGITS);
					end
				end
				ST_EMIT: begin
					digcnt_q <= digcnt_q - DIGCNT_W'(1);
					if (emit_now) begin
						strobe_q  <= 1'b1;
						started_q <= 1'b1;
					end
					if (digcnt_q == DIGCNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mag_q       <= value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
					bcd_q       <= '0;
					character_q <= CHAR_MINUS;
					last_q      <= 1'b0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
				mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			end
			ST_EMIT: begin
				bcd_q       <= {bcd_q[BCD_W-5:0], 4'd0};
				character_q <= {CHAR_DIGIT_HI, top_digit};
				last_q      <= (digcnt_q == DIGCNT_W'(1));
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;

	`SIDA_ASSERT_NEXT(a_req_goes_busy, clk, arst_n, start && !busy, busy)
	`SIDA_ASSERT_SAME(a_last_frees_block, clk, arst_n, strobe && last, !busy)
	`SIDA_ASSERT_SAME(a_minus_not_last, clk, arst_n, strobe && (character == CHAR_MINUS), !last)

endmodule

// ===== sim/signed_int_to_decimal_ascii_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Drives signed 32-bit values into the converter and checks each character
// and last flag against decimal text worked out locally. Runs directed
// corner values first, then random values of every digit length, with the
// request side idling at several rates.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

	import sida_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 50;
	localparam int RANDOM_PER_PHASE = 100;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              lst;
	} text_char_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic signed [VALUE_W-1:0]  value = '0;
	logic                       busy;
	logic                       strobe;
	logic        [CHAR_W-1:0]   character;
	logic                       last;

	logic [VALUE_W-1:0] pending_values[$];
	text_char_t         expected_text[$];
	logic               took = 1'b0;
	int                 idle_pct = 0;
	int                 requests_sent = 0;
	int                 requests_taken = 0;
	int                 mismatches = 0;
	int                 cycles = 0;

	signed_int_to_decimal_ascii u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.value    (value),
		.busy     (busy),
		.strobe   (strobe),
		.character(character),
		.last     (last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// decimal text of a 32-bit two's complement value, most significant first
	function automatic void push_decimal_text(input logic [VALUE_W-1:0] raw);
		logic               negative;
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digits[DIGITS];
		int                 ndig;
		int                 total;
		int                 n;
		text_char_t         c;
		negative = raw[VALUE_W-1];
		mag = negative ? (VALUE_W'(0) - raw) : raw;
		ndig = 0;
		n = 0;
		do begin
			digits[ndig] = 4'(mag % 10);
			mag = mag / 10;
			ndig++;
		end while (mag != 0 && ndig < DIGITS);
		total = ndig + (negative ? 1 : 0);
		if (negative) begin
			c.ch = CHAR_MINUS;
			c.lst = (n == total - 1);
			expected_text.push_back(c);
			n++;
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			c.ch = {CHAR_DIGIT_HI, digits[i]};
			c.lst = (n == total - 1);
			expected_text.push_back(c);
			n++;
		end
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		int unsigned k;
		int unsigned lo;
		int unsigned hi;
		logic [VALUE_W-1:0] mag;
		if ($urandom_range(99, 0) < 30)
			return $urandom();
		k = $urandom_range(10, 1);
		if (k == 10) begin
			mag = $urandom_range(32'hFFFF_FFFF, 32'd1_000_000_000);
		end else begin
			hi = 1;
			for (int i = 0; i < k; i++)
				hi = hi * 10;
			lo = (k == 1) ? 0 : hi / 10;
			mag = $urandom_range(hi - 1, lo);
		end
		return $urandom_range(1, 0) ? (VALUE_W'(0) - mag) : mag;
	endfunction

	task automatic send(input logic [VALUE_W-1:0] v);
		pending_values.push_back(v);
		requests_sent++;
	endtask

	task automatic wait_drained();
		while (requests_taken != requests_sent || expected_text.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// request still waiting for acceptance
		end else if (pending_values.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
			value <= pending_values.pop_front();
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// acceptance and character check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (start && !busy) begin
				push_decimal_text(value);
				requests_taken++;
			end
			if (strobe) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected character %0d", character));
				end else begin
					text_char_t e;
					e = expected_text.pop_front();
					if (character !== e.ch)
						report_mismatch($sformatf("character %0d, expected %0d",
							character, e.ch));
					if (last !== e.lst)
						report_mismatch($sformatf("last %b, expected %b", last, e.lst));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int phase_idle[4];
		phase_idle = '{0, 77, 38, 0};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(32'sd0);
		send(32'sd1);
		send(-32'sd1);
		send(32'sd9);
		send(32'sd10);
		send(-32'sd10);
		send(32'sd99);
		send(32'sd100);
		send(-32'sd9);
		send(32'sd2147483647);
		send(32'h8000_0000);
		send(32'h8000_0001);
		send(32'sd1000000000);
		send(-32'sd1000000000);
		send(32'sd999999999);
		send(-32'sd999999999);
		send(32'sd2147483640);
		send(32'h5555_5555);
		send(32'hAAAA_AAAA);
		send(32'sd1234567890);
		send(-32'sd100000);
		wait_drained();

		foreach (phase_idle[p]) begin
			@(posedge clk);
			idle_pct = phase_idle[p];
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				send(random_value());
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/sida_pkg.sv
design/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_test.sv
